// ----- hw/rtl/prq_pkg.sv -----
// Package for the priority request queue with lock.
// Holds field widths, operation and status codes, the datapath command set
// and the status bundle from datapath to controller. No dependencies.
package prq_pkg;

  localparam int OP_W     = 3;
  localparam int USER_W   = 4;
  localparam int PRIO_W   = 2;
  localparam int STATUS_W = 3;

  localparam int NUM_USERS_DEF = 16;
  localparam int NUM_PRIOS_DEF = 3;
  localparam int LOCK_MAX_DEF  = 255;

  typedef enum logic [OP_W-1:0] {
    OP_CONNECT    = 3'd0,
    OP_DISCONNECT = 3'd1,
    OP_QUEUE      = 3'd2,
    OP_CANCEL     = 3'd3,
    OP_LOCK       = 3'd4,
    OP_UNLOCK     = 3'd5,
    OP_DISPATCH   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 3'd0,
    ST_NOT_CONNECTED = 3'd1,
    ST_IS_QUEUED     = 3'd2,
    ST_IS_LOCKED     = 3'd3,
    ST_NOT_LOCKED    = 3'd4,
    ST_ALREADY_CONN  = 3'd5,
    ST_LOCK_FULL     = 3'd6
  } status_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_EXEC,
    CMD_SCAN,
    CMD_CHECK,
    CMD_SHRD,
    CMD_SHWR,
    CMD_HIRD,
    CMD_HIWR,
    CMD_PUSH
  } cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_CHECK,
    S_SHRD,
    S_SHWR,
    S_HIRD,
    S_HIWR,
    S_RESP
  } state_e;

  typedef struct packed {
    logic is_scan;
    logic need_head;
    logic scan_issue;
    logic last_prio;
    logic match;
    logic more_sh;
    logic more_hi;
  } dp_sts_t;

endpackage

// ----- hw/rtl/prq_if.sv -----
// Channel interfaces for the request and result transfers.
// Depend on prq_pkg for field widths.
interface prq_req_if;
  import prq_pkg::*;
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [USER_W-1:0]   user_id;
  logic [PRIO_W-1:0]   prio;
  modport source (output valid, operation, user_id, prio, input ready);
  modport sink   (input valid, operation, user_id, prio, output ready);
endinterface

interface prq_rsp_if;
  import prq_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                grant_valid;
  logic [USER_W-1:0]   grant_user;
  modport source (output valid, status, grant_valid, grant_user, input ready);
  modport sink   (input valid, status, grant_valid, grant_user, output ready);
endinterface

// ----- hw/rtl/prq_dp.sv -----
// Datapath: FIFO memory, per-user state, lock holder and result registers.
// Acts on one command per cycle from prq_ctrl; depends on prq_pkg.
module prq_dp import prq_pkg::*; #(
  parameter int NUM_USERS = NUM_USERS_DEF,
  parameter int NUM_PRIOS = NUM_PRIOS_DEF,
  parameter int LOCK_MAX  = LOCK_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_e                cmd_i,
  input  logic [OP_W-1:0]     op_i,
  input  logic [USER_W-1:0]   user_i,
  input  logic [PRIO_W-1:0]   prio_i,
  output dp_sts_t             sts_o,
  output logic [STATUS_W-1:0] status_o,
  output logic                grant_valid_o,
  output logic [USER_W-1:0]   grant_user_o
);

  localparam int UIW   = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int CW    = $clog2(NUM_USERS + 1);
  localparam int PW    = (NUM_PRIOS > 1) ? $clog2(NUM_PRIOS) : 1;
  localparam int DEPTH = NUM_PRIOS * NUM_USERS;
  localparam int AW    = $clog2(DEPTH);
  localparam int LCW   = $clog2(LOCK_MAX + 1);

  logic [USER_W-1:0] mem [DEPTH];
  logic [USER_W-1:0] rdata_q;

  logic [OP_W-1:0]   op_q;
  logic [USER_W-1:0] u_q;
  logic [PW-1:0]     p_q;
  logic [PW-1:0]     prio_q;
  logic [CW-1:0]     k_q;

  logic [CW-1:0]     cnt_q [NUM_PRIOS];
  logic              queued_q [NUM_USERS];
  logic              conn_q [NUM_USERS];
  logic [LCW-1:0]    lock_q [NUM_USERS];
  logic              holder_valid_q;
  logic [USER_W-1:0] holder_id_q;

  logic [STATUS_W-1:0] res_status_q, status_q;
  logic                res_gv_q, gv_q;
  logic [USER_W-1:0]   res_gu_q, gu_q;

  logic [PW-1:0]     cnt_idx;
  logic [CW-1:0]     sel_cnt;
  logic              u_ok;
  logic [UIW-1:0]    uidx;
  logic              conn, queued, is_holder, match;
  logic [LCW-1:0]    lcnt;
  logic              more_sh, more_hi, scan_issue, full;
  logic [STATUS_W-1:0] ex_status;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [USER_W-1:0] wr_data;

  function automatic logic [AW-1:0] addr_of(logic [PW-1:0] pr, logic [CW-1:0] k);
    addr_of = AW'(pr) * AW'(NUM_USERS) + AW'(k);
  endfunction

  always_comb begin
    cnt_idx    = (cmd_i == CMD_EXEC) ? p_q : prio_q;
    sel_cnt    = cnt_q[cnt_idx];
    u_ok       = int'(u_q) < NUM_USERS;
    uidx       = (cmd_i == CMD_CHECK && op_q == OP_DISPATCH) ? UIW'(rdata_q) : UIW'(u_q);
    conn       = u_ok && conn_q[uidx];
    queued     = queued_q[uidx];
    lcnt       = lock_q[uidx];
    is_holder  = holder_valid_q && (holder_id_q == u_q);
    match      = (op_q == OP_CANCEL) ? (rdata_q == u_q)
                                     : (!holder_valid_q || holder_id_q == rdata_q);
    scan_issue = k_q < sel_cnt;
    more_sh    = ({1'b0, k_q} + 1'b1) < {1'b0, sel_cnt};
    more_hi    = k_q != '0;
    full       = int'(sel_cnt) >= NUM_USERS;

    ex_status = ST_OK;
    case (op_q)
      OP_CONNECT: begin
        if (!u_ok) ex_status = ST_NOT_CONNECTED;
        else if (conn_q[uidx]) ex_status = ST_ALREADY_CONN;
      end
      OP_DISCONNECT: begin
        if (!conn) ex_status = ST_NOT_CONNECTED;
        else if (queued) ex_status = ST_IS_QUEUED;
        else if (lcnt != '0) ex_status = ST_IS_LOCKED;
      end
      OP_QUEUE: begin
        if (!conn) ex_status = ST_NOT_CONNECTED;
        else if (queued) ex_status = ST_IS_QUEUED;
      end
      OP_LOCK: begin
        if (!conn) ex_status = ST_NOT_CONNECTED;
        else if (queued) ex_status = ST_IS_QUEUED;
        else if (int'(lcnt) >= LOCK_MAX) ex_status = ST_LOCK_FULL;
      end
      OP_UNLOCK: begin
        if (!conn) ex_status = ST_NOT_CONNECTED;
        else if (queued) ex_status = ST_IS_QUEUED;
        else if (lcnt == '0) ex_status = ST_NOT_LOCKED;
      end
      default: ex_status = ST_OK;
    endcase

    sts_o.is_scan    = (op_q == OP_CANCEL) || (op_q == OP_DISPATCH);
    sts_o.need_head  = (op_q == OP_QUEUE) && (ex_status == ST_OK) && is_holder && !full;
    sts_o.scan_issue = scan_issue;
    sts_o.last_prio  = prio_q == '0;
    sts_o.match      = match;
    sts_o.more_sh    = more_sh;
    sts_o.more_hi    = more_hi;

    rd_en   = 1'b0;
    rd_addr = addr_of(prio_q, k_q);
    wr_en   = 1'b0;
    wr_addr = addr_of(prio_q, k_q);
    wr_data = rdata_q;
    case (cmd_i)
      CMD_EXEC: begin
        wr_addr = addr_of(p_q, sel_cnt);
        wr_data = u_q;
        wr_en   = (op_q == OP_QUEUE) && (ex_status == ST_OK) && !is_holder && !full;
      end
      CMD_SCAN: rd_en = scan_issue;
      CMD_SHRD: begin
        rd_en   = more_sh;
        rd_addr = addr_of(prio_q, k_q) + AW'(1);
      end
      CMD_SHWR: wr_en = 1'b1;
      CMD_HIRD: begin
        rd_en   = more_hi;
        rd_addr = addr_of(prio_q, k_q) - AW'(1);
        wr_en   = !more_hi;
        wr_addr = addr_of(prio_q, '0);
        wr_data = u_q;
      end
      CMD_HIWR: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i)
      CMD_LOAD: begin
        op_q <= op_i;
        u_q  <= user_i;
        p_q  <= (int'(prio_i) >= NUM_PRIOS) ? PW'(NUM_PRIOS - 1) : PW'(prio_i);
      end
      CMD_EXEC: begin
        res_status_q <= ex_status;
        res_gv_q     <= 1'b0;
        res_gu_q     <= '0;
        if (op_q == OP_QUEUE) begin
          prio_q <= p_q;
          k_q    <= sel_cnt;
        end else begin
          prio_q <= PW'(NUM_PRIOS - 1);
          k_q    <= '0;
        end
      end
      CMD_SCAN: begin
        if (!scan_issue && prio_q != '0) begin
          prio_q <= prio_q - 1'b1;
          k_q    <= '0;
        end
      end
      CMD_CHECK: begin
        if (match) begin
          if (op_q == OP_DISPATCH) begin
            res_gv_q <= 1'b1;
            res_gu_q <= rdata_q;
          end
        end else begin
          k_q <= k_q + 1'b1;
        end
      end
      CMD_SHWR: k_q <= k_q + 1'b1;
      CMD_HIWR: k_q <= k_q - 1'b1;
      CMD_PUSH: begin
        status_q <= res_status_q;
        gv_q     <= res_gv_q;
        gu_q     <= res_gu_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PRIOS; i++) cnt_q[i] <= '0;
      for (int i = 0; i < NUM_USERS; i++) begin
        queued_q[i] <= 1'b0;
        conn_q[i]   <= 1'b0;
        lock_q[i]   <= '0;
      end
      holder_valid_q <= 1'b0;
      holder_id_q    <= '0;
    end else begin
      case (cmd_i)
        CMD_EXEC: begin
          if (ex_status == ST_OK) begin
            case (op_q)
              OP_CONNECT:    conn_q[uidx] <= 1'b1;
              OP_DISCONNECT: conn_q[uidx] <= 1'b0;
              OP_QUEUE: begin
                queued_q[uidx] <= 1'b1;
                if (wr_en) cnt_q[cnt_idx] <= sel_cnt + 1'b1;
              end
              OP_LOCK:       lock_q[uidx] <= lcnt + 1'b1;
              OP_UNLOCK: begin
                lock_q[uidx] <= lcnt - 1'b1;
                if (is_holder) holder_valid_q <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        CMD_CHECK: begin
          if (match) begin
            queued_q[uidx] <= 1'b0;
            if (op_q == OP_DISPATCH && lcnt != '0) begin
              holder_valid_q <= 1'b1;
              holder_id_q    <= rdata_q;
            end
          end
        end
        CMD_SHRD: if (!more_sh) cnt_q[cnt_idx] <= sel_cnt - 1'b1;
        CMD_HIRD: if (!more_hi) cnt_q[cnt_idx] <= sel_cnt + 1'b1;
        default: ;
      endcase
    end
  end

  assign status_o      = status_q;
  assign grant_valid_o = gv_q;
  assign grant_user_o  = gu_q;

endmodule

// ----- hw/rtl/prq_ctrl.sv -----
// Controller: sequences load, execute, FIFO scan and shift, and result push.
// Drives datapath commands and the channel handshakes; depends on prq_pkg.
module prq_ctrl import prq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output cmd_e    cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd_o = CMD_EXEC;
        if (sts_i.is_scan) state_d = S_SCAN;
        else if (sts_i.need_head) state_d = S_HIRD;
        else state_d = S_RESP;
      end
      S_SCAN: begin
        cmd_o = CMD_SCAN;
        if (sts_i.scan_issue) state_d = S_CHECK;
        else if (sts_i.last_prio) state_d = S_RESP;
      end
      S_CHECK: begin
        cmd_o   = CMD_CHECK;
        state_d = sts_i.match ? S_SHRD : S_SCAN;
      end
      S_SHRD: begin
        cmd_o   = CMD_SHRD;
        state_d = sts_i.more_sh ? S_SHWR : S_RESP;
      end
      S_SHWR: begin
        cmd_o   = CMD_SHWR;
        state_d = S_SHRD;
      end
      S_HIRD: begin
        cmd_o   = CMD_HIRD;
        state_d = sts_i.more_hi ? S_HIWR : S_RESP;
      end
      S_HIWR: begin
        cmd_o   = CMD_HIWR;
        state_d = S_HIRD;
      end
      S_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o       = CMD_PUSH;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/priority_request_queue_with_lock_unit.sv -----
// Priority request queue with lock owner: top level.
// Connect, disconnect, lock, unlock, tail queue and unused codes go straight from execute
// to the result; cancel and dispatch scan the FIFOs from the highest priority down, and
// removal or head insert shifts the entries one at a time through the memory.
// One request in flight; take the next while a result waits at the output.
// Asynchronous active-low reset clears control and user state.
module priority_request_queue_with_lock_unit import prq_pkg::*; #(
  parameter int NUM_USERS = NUM_USERS_DEF,
  parameter int NUM_PRIOS = NUM_PRIOS_DEF,
  parameter int LOCK_MAX  = LOCK_MAX_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  prq_req_if.sink  req_i,
  prq_rsp_if.source rsp_o
);

  cmd_e    cmd;
  dp_sts_t sts;

  prq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  prq_dp #(
    .NUM_USERS (NUM_USERS),
    .NUM_PRIOS (NUM_PRIOS),
    .LOCK_MAX  (LOCK_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (req_i.operation),
    .user_i        (req_i.user_id),
    .prio_i        (req_i.prio),
    .sts_o         (sts),
    .status_o      (rsp_o.status),
    .grant_valid_o (rsp_o.grant_valid),
    .grant_user_o  (rsp_o.grant_user)
  );

endmodule

// ----- verif/tb_prq_chan_if.sv -----
// Testbench-side view of the request and result channels.
// The RTL interfaces prq_req_if and prq_rsp_if (hw/rtl/prq_if.sv) are used
// directly; this file only holds the transfer records shared by the bench.
package tb_prq_chan_pkg;
  import prq_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [USER_W-1:0] user_id;
    logic [PRIO_W-1:0] prio;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                grant_valid;
    logic [USER_W-1:0]   grant_user;
  } rsp_t;
endpackage

// ----- verif/tb_priority_request_queue_with_lock_unit.sv -----
// Testbench for priority_request_queue_with_lock_unit: random and directed
// scheduler requests, a behavioural scheduler model predicts every result.
// Depends on prq_pkg, prq_if and tb_prq_chan_pkg.
module tb_priority_request_queue_with_lock_unit;
  import prq_pkg::*;
  import tb_prq_chan_pkg::*;

  localparam int NU = NUM_USERS_DEF;
  localparam int NP = NUM_PRIOS_DEF;
  localparam int LMAX = LOCK_MAX_DEF;
  localparam int IDLE_LIMIT = 4000;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  prq_req_if req_if ();
  prq_rsp_if rsp_if ();

  priority_request_queue_with_lock_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if.sink),
    .rsp_o  (rsp_if.source)
  );

  // scheduler state mirror
  logic [USER_W-1:0] sched_fifo [NP][NU];
  int                sched_cnt [NP];
  bit                sched_queued [NU];
  bit                sched_conn [NU];
  int                sched_locks [NU];
  bit                sched_hold_v;
  logic [USER_W-1:0] sched_hold_id;

  req_t pending_reqs [$];
  rsp_t expected_rsps [$];
  int   mismatches = 0;
  bit   stim_done = 0;
  bit   long_hold = 0;
  int   idle_cycles = 0;
  int   sent_cnt = 0;

  function automatic void sched_remove(int p, int pos);
    for (int k = pos; k + 1 < sched_cnt[p]; k++) sched_fifo[p][k] = sched_fifo[p][k+1];
    sched_cnt[p]--;
  endfunction

  function automatic rsp_t sched_step(req_t r);
    rsp_t o;
    int   p;
    int   u;
    bit   conn;
    bit   found;
    o = '0;
    u = r.user_id;
    p = (r.prio >= NP) ? NP - 1 : r.prio;
    conn = sched_conn[u];
    case (r.operation)
      OP_CONNECT: begin
        if (conn) o.status = ST_ALREADY_CONN;
        else sched_conn[u] = 1;
      end
      OP_DISCONNECT: begin
        if (!conn) o.status = ST_NOT_CONNECTED;
        else if (sched_queued[u]) o.status = ST_IS_QUEUED;
        else if (sched_locks[u] > 0) o.status = ST_IS_LOCKED;
        else sched_conn[u] = 0;
      end
      OP_QUEUE: begin
        if (!conn) o.status = ST_NOT_CONNECTED;
        else if (sched_queued[u]) o.status = ST_IS_QUEUED;
        else begin
          if (sched_hold_v && sched_hold_id == u) begin
            for (int k = sched_cnt[p]; k > 0; k--) sched_fifo[p][k] = sched_fifo[p][k-1];
            sched_fifo[p][0] = USER_W'(u);
          end else sched_fifo[p][sched_cnt[p]] = USER_W'(u);
          sched_cnt[p]++;
          sched_queued[u] = 1;
        end
      end
      OP_CANCEL: begin
        found = 0;
        for (int i = NP - 1; i >= 0 && !found; i--)
          for (int k = 0; k < sched_cnt[i] && !found; k++)
            if (sched_fifo[i][k] == u) begin
              sched_remove(i, k);
              sched_queued[u] = 0;
              found = 1;
            end
      end
      OP_LOCK: begin
        if (!conn) o.status = ST_NOT_CONNECTED;
        else if (sched_queued[u]) o.status = ST_IS_QUEUED;
        else if (sched_locks[u] >= LMAX) o.status = ST_LOCK_FULL;
        else sched_locks[u]++;
      end
      OP_UNLOCK: begin
        if (!conn) o.status = ST_NOT_CONNECTED;
        else if (sched_queued[u]) o.status = ST_IS_QUEUED;
        else if (sched_locks[u] == 0) o.status = ST_NOT_LOCKED;
        else begin
          sched_locks[u]--;
          if (sched_hold_v && sched_hold_id == u) sched_hold_v = 0;
        end
      end
      OP_DISPATCH: begin
        for (int i = NP - 1; i >= 0 && !o.grant_valid; i--)
          for (int k = 0; k < sched_cnt[i] && !o.grant_valid; k++)
            if (!sched_hold_v || sched_hold_id == sched_fifo[i][k]) begin
              o.grant_user = sched_fifo[i][k];
              sched_remove(i, k);
              sched_queued[o.grant_user] = 0;
              if (sched_locks[o.grant_user] > 0) begin
                sched_hold_v = 1;
                sched_hold_id = o.grant_user;
              end
              o.grant_valid = 1;
            end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic req_t mk_req(logic [OP_W-1:0] op, int u, int p);
    req_t r;
    r.operation = op;
    r.user_id = USER_W'(u);
    r.prio = PRIO_W'(p);
    return r;
  endfunction

  initial forever #5 clk_i = ~clk_i;

  initial begin
    int u;
    int pick;
    for (int i = 0; i < NU; i++) begin
      sched_queued[i] = 0;
      sched_conn[i] = 0;
      sched_locks[i] = 0;
    end
    for (int i = 0; i < NP; i++) sched_cnt[i] = 0;
    sched_hold_v = 0;
    sched_hold_id = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: every operation, extremes, unused code, prio 3
    pending_reqs.push_back(mk_req(OP_DISCONNECT, 0, 0));
    pending_reqs.push_back(mk_req(OP_QUEUE, 15, 1));
    pending_reqs.push_back(mk_req(OP_LOCK, 15, 0));
    pending_reqs.push_back(mk_req(OP_UNLOCK, 15, 0));
    pending_reqs.push_back(mk_req(OP_CONNECT, 0, 0));
    pending_reqs.push_back(mk_req(OP_CONNECT, 15, 3));
    pending_reqs.push_back(mk_req(OP_CONNECT, 15, 0));
    pending_reqs.push_back(mk_req(OP_UNLOCK, 0, 0));
    pending_reqs.push_back(mk_req(OP_DISPATCH, 0, 0));
    pending_reqs.push_back(mk_req(OP_QUEUE, 0, 0));
    pending_reqs.push_back(mk_req(OP_QUEUE, 15, 3));
    pending_reqs.push_back(mk_req(OP_QUEUE, 15, 2));
    pending_reqs.push_back(mk_req(OP_LOCK, 0, 0));
    pending_reqs.push_back(mk_req(OP_DISCONNECT, 0, 0));
    pending_reqs.push_back(mk_req(OP_UNUSED, 15, 3));
    pending_reqs.push_back(mk_req(OP_CANCEL, 0, 0));
    pending_reqs.push_back(mk_req(OP_CANCEL, 0, 0));
    pending_reqs.push_back(mk_req(OP_LOCK, 0, 0));
    pending_reqs.push_back(mk_req(OP_DISCONNECT, 0, 0));
    pending_reqs.push_back(mk_req(OP_QUEUE, 0, 1));
    pending_reqs.push_back(mk_req(OP_DISPATCH, 0, 0));
    pending_reqs.push_back(mk_req(OP_QUEUE, 0, 0));
    pending_reqs.push_back(mk_req(OP_DISPATCH, 0, 0));
    pending_reqs.push_back(mk_req(OP_DISPATCH, 0, 0));
    pending_reqs.push_back(mk_req(OP_UNLOCK, 0, 0));
    // saturate one lock count
    pending_reqs.push_back(mk_req(OP_CONNECT, 7, 0));
    for (int i = 0; i < 256; i++) pending_reqs.push_back(mk_req(OP_LOCK, 7, 0));
    pending_reqs.push_back(mk_req(OP_UNLOCK, 7, 0));
    pending_reqs.push_back(mk_req(OP_LOCK, 7, 0));
    for (int i = 0; i < 10; i++) pending_reqs.push_back(mk_req(OP_UNLOCK, 7, 0));

    // random: mostly connect/queue/dispatch traffic on a few users
    for (int i = 0; i < 110; i++) begin
      u = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 5);
      pick = $urandom_range(0, 99);
      if (pick < 12) pending_reqs.push_back(mk_req(OP_CONNECT, u, 0));
      else if (pick < 17) pending_reqs.push_back(mk_req(OP_DISCONNECT, u, 0));
      else if (pick < 45) pending_reqs.push_back(mk_req(OP_QUEUE, u, $urandom_range(0, 3)));
      else if (pick < 52) pending_reqs.push_back(mk_req(OP_CANCEL, u, $urandom_range(0, 3)));
      else if (pick < 60) pending_reqs.push_back(mk_req(OP_LOCK, u, $urandom_range(0, 3)));
      else if (pick < 68) pending_reqs.push_back(mk_req(OP_UNLOCK, u, 0));
      else if (pick < 98) pending_reqs.push_back(mk_req(OP_DISPATCH, u, $urandom_range(0, 3)));
      else pending_reqs.push_back(mk_req(OP_UNUSED, u, $urandom_range(0, 3)));
    end
    stim_done = 1;
  end

  // driver: bursts with gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.operation <= '0;
      req_if.user_id <= '0;
      req_if.prio <= '0;
    end else if (req_if.valid && !req_if.ready) begin
      // hold
    end else begin
      if (req_if.valid) begin
        expected_rsps.push_back(
          sched_step(mk_req(req_if.operation, req_if.user_id, req_if.prio)));
        sent_cnt <= sent_cnt + 1;
      end
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_if.valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req_t r;
        r = pending_reqs.pop_front();
        req_if.valid <= 1'b1;
        req_if.operation <= r.operation;
        req_if.user_id <= r.user_id;
        req_if.prio <= r.prio;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else burst_left <= burst_left - 1;
      end else req_if.valid <= 1'b0;
    end
  end

  // receiver stall pattern, one long hold-off early on
  int hold_cnt = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rsp_if.ready <= 1'b0;
    else if (!long_hold && sent_cnt >= 30) begin
      long_hold <= 1;
      hold_cnt <= 300;
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      rsp_if.ready <= 1'b0;
    end else rsp_if.ready <= ($urandom_range(0, 7) < ((sent_cnt / 40) % 2 ? 8 : 5));
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %0d %0d %0d", rsp_if.status,
          rsp_if.grant_valid, rsp_if.grant_user);
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (e.status !== rsp_if.status || e.grant_valid !== rsp_if.grant_valid ||
            e.grant_user !== rsp_if.grant_user) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %0d/%0d/%0d got %0d/%0d/%0d", e.status, e.grant_valid,
              e.grant_user, rsp_if.status, rsp_if.grant_valid, rsp_if.grant_user);
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int tail;
    tail = 0;
    while (tail < 200 && idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (stim_done && pending_reqs.size() == 0 && !req_if.valid &&
          expected_rsps.size() == 0) tail++;
      else tail = 0;
    end
    if (idle_cycles >= IDLE_LIMIT) $display("status: fail");
    else if (mismatches == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
